>>> sv/upi_pkg.sv
// Shared types, constants and the arctangent table of the pose integrator.
package upi_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_RUN   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W       = $clog2(ATAN_ENTRIES);

    localparam logic [15:0] TIME_STEP_RESET = 16'd655;

    // 2^16/(2pi) as Q16, split into two 15-bit halves: HI * 2^15 + LO
    localparam logic signed [16:0] RAD2TURN_LO = 17'sd24796;
    localparam logic signed [16:0] RAD2TURN_HI = 17'sd20860;

    localparam logic signed [33:0] CORDIC_START  = 34'sd652032874;
    localparam logic signed [33:0] HALF_PI_TURNS = 34'sd1073741824;
    localparam logic signed [33:0] PI_TURNS      = 34'sd2147483648;

    localparam logic signed [63:0] ANG_ROUND = 64'sh0000_0400_0000_0000;
    localparam logic signed [63:0] POS_ROUND = 64'sh0000_0020_0000_0000;

    typedef enum logic [1:0] {
        REG_TIME_STEP     = 2'd0,
        REG_START_X       = 2'd1,
        REG_START_Y       = 2'd2,
        REG_START_HEADING = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        MUL_NONE    = 4'd0,
        MUL_DT_W    = 4'd1,
        MUL_P_RLO   = 4'd2,
        MUL_P_RHI   = 4'd3,
        MUL_U_DT    = 4'd4,
        MUL_UDT_CXL = 4'd5,
        MUL_UDT_CXH = 4'd6,
        MUL_UDT_CYL = 4'd7,
        MUL_UDT_CYH = 4'd8
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD  = 2'd0,
        ACC_LOAD  = 2'd1,
        ACC_ADD15 = 2'd2,
        ACC_ADD16 = 2'd3
    } acc_op_t;

    typedef struct packed {
        logic              accept;
        logic              p_load;
        logic              d_load;
        logic              udt_load;
        logic              cordic_init;
        logic              cordic_step;
        logic [STEP_W-1:0] step;
        logic              delta_load;
        logic              x_update;
        logic              commit;
        mul_sel_t          mul_sel;
        acc_op_t           acc_op;
    } cmd_t;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [29:0] atan_turns(input logic [STEP_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10680862;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/upi_ctrl.sv
// Sequencer of the pose integrator: steps the datapath and owns both handshakes.
module upi_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output upi_pkg::cmd_t   cmd
);

    typedef enum logic [14:0] {
        ST_IDLE  = 15'h0001,
        ST_PMUL  = 15'h0002,
        ST_RLO   = 15'h0004,
        ST_RHI   = 15'h0008,
        ST_ACC   = 15'h0010,
        ST_ANG   = 15'h0020,
        ST_CINIT = 15'h0040,
        ST_CROT  = 15'h0080,
        ST_XLO   = 15'h0100,
        ST_XHI   = 15'h0200,
        ST_YLO   = 15'h0400,
        ST_YHI   = 15'h0800,
        ST_XUPD  = 15'h1000,
        ST_YRND  = 15'h2000,
        ST_DONE  = 15'h4000
    } state_t;

    state_t                      state_reg, state_next;
    logic [upi_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        cmd            = '0;
        cmd.mul_sel    = upi_pkg::MUL_NONE;
        cmd.acc_op     = upi_pkg::ACC_HOLD;
        cmd.step       = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL: begin
                cmd.mul_sel = upi_pkg::MUL_DT_W;
                state_next  = ST_RLO;
            end
            ST_RLO: begin
                cmd.p_load  = 1'b1;
                cmd.mul_sel = upi_pkg::MUL_P_RLO;
                state_next  = ST_RHI;
            end
            ST_RHI: begin
                cmd.mul_sel = upi_pkg::MUL_P_RHI;
                cmd.acc_op  = upi_pkg::ACC_LOAD;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.mul_sel = upi_pkg::MUL_U_DT;
                cmd.acc_op  = upi_pkg::ACC_ADD15;
                state_next  = ST_ANG;
            end
            ST_ANG: begin
                cmd.d_load   = 1'b1;
                cmd.udt_load = 1'b1;
                state_next   = ST_CINIT;
            end
            ST_CINIT: begin
                cmd.cordic_init = 1'b1;
                step_next       = '0;
                state_next      = ST_CROT;
            end
            ST_CROT: begin
                cmd.cordic_step = 1'b1;
                if (step_reg == upi_pkg::STEP_W'(upi_pkg::CORDIC_RUN - 1)) begin
                    state_next = ST_XLO;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_XLO: begin
                cmd.mul_sel = upi_pkg::MUL_UDT_CXL;
                state_next  = ST_XHI;
            end
            ST_XHI: begin
                cmd.mul_sel = upi_pkg::MUL_UDT_CXH;
                cmd.acc_op  = upi_pkg::ACC_LOAD;
                state_next  = ST_YLO;
            end
            ST_YLO: begin
                cmd.mul_sel = upi_pkg::MUL_UDT_CYL;
                cmd.acc_op  = upi_pkg::ACC_ADD16;
                state_next  = ST_YHI;
            end
            ST_YHI: begin
                cmd.mul_sel    = upi_pkg::MUL_UDT_CYH;
                cmd.acc_op     = upi_pkg::ACC_LOAD;
                cmd.delta_load = 1'b1;
                state_next     = ST_XUPD;
            end
            ST_XUPD: begin
                cmd.acc_op   = upi_pkg::ACC_ADD16;
                cmd.x_update = 1'b1;
                state_next   = ST_YRND;
            end
            ST_YRND: begin
                cmd.delta_load = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

>>> sv/upi_datapath.sv
// Datapath: config and pose registers, shared multiplier, accumulator, serial CORDIC.
module upi_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  upi_pkg::cmd_t        cmd,
    input  logic [31:0]          s_tdata,
    input  logic                 s_tuser,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_wdata,
    output logic [79:0]          m_tdata
);

    logic        [15:0] time_step_reg;
    logic        [31:0] start_x_reg;
    logic        [31:0] start_y_reg;
    logic        [15:0] start_heading_reg;

    logic        [31:0] pose_x_reg;
    logic        [31:0] pose_y_reg;
    logic        [15:0] pose_heading_reg;

    logic signed [15:0] speed_reg;
    logic signed [15:0] turn_rate_reg;

    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_reg;
    logic signed [63:0] mul_wide;
    logic signed [63:0] acc_reg;
    logic signed [63:0] ang_sum;
    logic signed [63:0] pos_sum;

    logic signed [31:0] p_reg;
    logic signed [31:0] udt_reg;
    logic        [16:0] d_reg;
    logic        [31:0] delta_reg;

    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic signed [33:0] c_x, c_y;
    logic signed [33:0] xs, ys, at;
    logic        [16:0] mid;
    logic signed [33:0] z0;

    logic        [31:0] out_x_reg;
    logic        [31:0] out_y_reg;
    logic        [15:0] out_h_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg     <= upi_pkg::TIME_STEP_RESET;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_heading_reg <= '0;
        end else if (cfg_we) begin
            unique case (upi_pkg::reg_index_t'(cfg_index))
                upi_pkg::REG_TIME_STEP:     time_step_reg     <= cfg_wdata[15:0];
                upi_pkg::REG_START_X:       start_x_reg       <= cfg_wdata;
                upi_pkg::REG_START_Y:       start_y_reg       <= cfg_wdata;
                upi_pkg::REG_START_HEADING: start_heading_reg <= cfg_wdata[15:0];
            endcase
        end
    end

    // pose
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pose_x_reg       <= '0;
            pose_y_reg       <= '0;
            pose_heading_reg <= '0;
        end else begin
            if (cmd.accept && s_tuser) begin
                pose_x_reg       <= start_x_reg;
                pose_y_reg       <= start_y_reg;
                pose_heading_reg <= start_heading_reg;
            end
            if (cmd.x_update) begin
                pose_x_reg <= pose_x_reg + delta_reg;
            end
            if (cmd.commit) begin
                pose_y_reg       <= pose_y_reg + delta_reg;
                pose_heading_reg <= pose_heading_reg + d_reg[15:0];
            end
        end
    end

    // flipped CORDIC outputs give cos and sin
    assign c_x = flip_reg ? -cx_reg : cx_reg;
    assign c_y = flip_reg ? -cy_reg : cy_reg;

    always_comb begin
        case (cmd.mul_sel)
            upi_pkg::MUL_DT_W: begin
                mul_a = {17'b0, time_step_reg};
                mul_b = {turn_rate_reg[15], turn_rate_reg};
            end
            upi_pkg::MUL_P_RLO: begin
                mul_a = {mul_reg[31], mul_reg[31:0]};
                mul_b = upi_pkg::RAD2TURN_LO;
            end
            upi_pkg::MUL_P_RHI: begin
                mul_a = {p_reg[31], p_reg};
                mul_b = upi_pkg::RAD2TURN_HI;
            end
            upi_pkg::MUL_U_DT: begin
                mul_a = {{17{speed_reg[15]}}, speed_reg};
                mul_b = {1'b0, time_step_reg};
            end
            upi_pkg::MUL_UDT_CXL: begin
                mul_a = {udt_reg[31], udt_reg};
                mul_b = {1'b0, c_x[15:0]};
            end
            upi_pkg::MUL_UDT_CXH: begin
                mul_a = {udt_reg[31], udt_reg};
                mul_b = {c_x[31], c_x[31:16]};
            end
            upi_pkg::MUL_UDT_CYL: begin
                mul_a = {udt_reg[31], udt_reg};
                mul_b = {1'b0, c_y[15:0]};
            end
            upi_pkg::MUL_UDT_CYH: begin
                mul_a = {udt_reg[31], udt_reg};
                mul_b = {c_y[31], c_y[31:16]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_wide = {{14{mul_reg[49]}}, mul_reg};
    assign ang_sum  = acc_reg + upi_pkg::ANG_ROUND;
    assign pos_sum  = acc_reg + upi_pkg::POS_ROUND;

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        case (cmd.acc_op)
            upi_pkg::ACC_LOAD:  acc_reg <= mul_wide;
            upi_pkg::ACC_ADD15: acc_reg <= acc_reg + (mul_wide <<< 15);
            upi_pkg::ACC_ADD16: acc_reg <= acc_reg + (mul_wide <<< 16);
            default:            acc_reg <= acc_reg;
        endcase
        if (cmd.accept) begin
            speed_reg     <= s_tdata[15:0];
            turn_rate_reg <= s_tdata[31:16];
        end
        if (cmd.p_load) begin
            p_reg <= mul_reg[31:0];
        end
        if (cmd.d_load) begin
            d_reg <= ang_sum[59:43];
        end
        if (cmd.udt_load) begin
            udt_reg <= mul_reg[31:0];
        end
        if (cmd.delta_load) begin
            delta_reg <= {{6{pos_sum[63]}}, pos_sum[63:38]};
        end
    end

    // CORDIC: midpoint angle in 2pi/2^17 units, folded into +-pi/2
    assign mid = {pose_heading_reg, 1'b0} + d_reg;
    assign z0  = {{2{mid[16]}}, mid, 15'b0};
    assign xs  = cx_reg >>> cmd.step;
    assign ys  = cy_reg >>> cmd.step;
    assign at  = {4'b0, upi_pkg::atan_turns(cmd.step)};

    always_ff @(posedge aclk) begin
        if (cmd.cordic_init) begin
            cx_reg <= upi_pkg::CORDIC_START;
            cy_reg <= '0;
            if (z0 > upi_pkg::HALF_PI_TURNS) begin
                cz_reg   <= z0 - upi_pkg::PI_TURNS;
                flip_reg <= 1'b1;
            end else if (z0 < -upi_pkg::HALF_PI_TURNS) begin
                cz_reg   <= z0 + upi_pkg::PI_TURNS;
                flip_reg <= 1'b1;
            end else begin
                cz_reg   <= z0;
                flip_reg <= 1'b0;
            end
        end else if (cmd.cordic_step) begin
            if (!cz_reg[33]) begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - at;
            end else begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + at;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_x_reg <= pose_x_reg;
            out_y_reg <= pose_y_reg + delta_reg;
            out_h_reg <= pose_heading_reg + d_reg[15:0];
        end
    end

    assign m_tdata = {out_h_reg, out_y_reg, out_x_reg};

endmodule

>>> sv/unicycle_pose_integrator_unit.sv
// Top level of the midpoint-rule unicycle pose integrator.
//
//  channel   dir  handshake            payload (low bit up)
//  s_        in   s_tvalid/s_tready    tdata: speed[15:0], turn_rate[31:16]; tuser: restart
//  m_        out  m_tvalid/m_tready    tdata: pos_x[31:0], pos_y[63:32], heading[79:64]
//  cfg_      in   cfg_we               cfg_index selects register, cfg_wdata value
//
//  One word is worked on at a time, from accept to the next accept: the serial CORDIC
//  loop of CORDIC_RUN (16) rotations and the single shared 33x17 multiplier set the pace.
//  The result sits in an output register; the next word is taken while it waits.
//  A word finished while the previous result is still untaken holds in its last step.
//  Synchronous active-low reset: pose zero, time step 655, start pose zero.
module unicycle_pose_integrator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // speed[15:0], turn_rate[31:16]
    input  logic        s_tuser,   // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // pos_x[31:0], pos_y[63:32], heading[79:64]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    upi_pkg::cmd_t cmd;

    upi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    upi_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

endmodule

>>> sv/upi_checker.sv
// Port-level assertions for the pose integrator, bound to the top level.
module upi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // held result must not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a word in flight blocks the input
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in flight");

    // a new result only comes from a finishing word
    a_rise_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a word in flight");

    // the unit is idle again once a result appears
    a_rise_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("unit not idle after delivering a result");

endmodule

bind unicycle_pose_integrator_unit upi_checker u_upi_checker (.*);

>>> verif/tb.sv
// Self-checking testbench for unicycle_pose_integrator_unit: predicts each pose word and compares.
module tb;

    typedef struct packed {
        logic [15:0] h;
        logic [31:0] y;
        logic [31:0] x;
    } pose_t;

    localparam longint RAD_TO_TURN  = 64'sd683565276;      // 2^16/(2pi), Q16
    localparam longint ANGLE_BIAS   = 64'sh0000_0400_0000_0000;
    localparam longint POS_BIAS     = 64'sh0000_0020_0000_0000;
    localparam longint GAIN_START   = 64'sd652032874;      // 0.60725 in Q1.30
    localparam longint QUARTER_TURN = 64'sd1073741824;
    localparam longint HALF_TURN    = 64'sd2147483648;
    localparam longint ARC_TURNS [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };
    localparam int DRAIN_CYCLES = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    logic [15:0] time_step_q;
    logic [31:0] start_x_q;
    logic [31:0] start_y_q;
    logic [15:0] start_heading_q;
    logic [31:0] pose_x_q;
    logic [31:0] pose_y_q;
    logic [15:0] pose_heading_q;

    pose_t pose_queue[$];
    int    words_sent;
    int    results_seen;
    int    mismatches;
    int    restarts;
    int    settings;
    bit    sender_idle;
    bit    sink_stall;

    unicycle_pose_integrator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // midpoint-rule pose update, advances the predicted pose
    function automatic pose_t integrate_step(input bit restart, input logic signed [15:0] speed,
                                             input logic signed [15:0] turn);
        longint      dt_l, spd_l, turn_l, d_ang, mid_l, z, cx, sy, xs, ys, udt, dx, dy;
        logic [16:0] mid;
        logic signed [31:0] z32;
        bit          flip;
        pose_t       r;
        if (restart) begin
            pose_x_q       = start_x_q;
            pose_y_q       = start_y_q;
            pose_heading_q = start_heading_q;
        end
        dt_l   = longint'(time_step_q);
        spd_l  = longint'(speed);
        turn_l = longint'(turn);
        d_ang  = (dt_l * turn_l * RAD_TO_TURN + ANGLE_BIAS) >>> 43;
        mid_l  = longint'(pose_heading_q) * 2 + d_ang;
        mid    = mid_l[16:0];
        z32    = {mid, 15'd0};
        z      = longint'(z32);
        flip   = 1'b0;
        if (z > QUARTER_TURN) begin
            z    = z - HALF_TURN;
            flip = 1'b1;
        end else if (z < -QUARTER_TURN) begin
            z    = z + HALF_TURN;
            flip = 1'b1;
        end
        cx = GAIN_START;
        sy = 0;
        for (int i = 0; i < upi_pkg::CORDIC_RUN; i++) begin
            xs = cx >>> i;
            ys = sy >>> i;
            if (z >= 0) begin
                cx = cx - ys;
                sy = sy + xs;
                z  = z - ARC_TURNS[i];
            end else begin
                cx = cx + ys;
                sy = sy - xs;
                z  = z + ARC_TURNS[i];
            end
        end
        if (flip) begin
            cx = -cx;
            sy = -sy;
        end
        udt = spd_l * dt_l;
        dx  = (udt * cx + POS_BIAS) >>> 38;
        dy  = (udt * sy + POS_BIAS) >>> 38;
        pose_x_q       = pose_x_q + dx[31:0];
        pose_y_q       = pose_y_q + dy[31:0];
        pose_heading_q = pose_heading_q + d_ang[15:0];
        r.x = pose_x_q;
        r.y = pose_y_q;
        r.h = pose_heading_q;
        return r;
    endfunction

    task automatic send_word(input bit restart, input logic [15:0] speed, input logic [15:0] turn);
        int gap;
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {turn, speed};
        s_tuser  = restart;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pose_queue.push_back(integrate_step(restart, speed, turn));
        words_sent++;
        if (restart)
            restarts++;
    endtask

    task automatic send_random_word();
        logic [15:0] spd;
        logic [15:0] trn;
        spd = 16'($urandom);
        trn = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
            spd = {{7{spd[15]}}, spd[8:0]};
        if ($urandom_range(0, 3) == 0)
            trn = {{7{trn[15]}}, trn[8:0]};
        send_word($urandom_range(0, 31) == 0, spd, trn);
    endtask

    // hold the sender until every pose word is back and the block has settled
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pose_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input upi_pkg::reg_index_t idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            upi_pkg::REG_TIME_STEP:     time_step_q     = value[15:0];
            upi_pkg::REG_START_X:       start_x_q       = value;
            upi_pkg::REG_START_Y:       start_y_q       = value;
            upi_pkg::REG_START_HEADING: start_heading_q = value[15:0];
            default: ;
        endcase
    endtask

    task automatic write_pose_regs(input logic [15:0] dt, input logic [31:0] sx,
                                   input logic [31:0] sy, input logic [15:0] sh);
        write_reg(upi_pkg::REG_TIME_STEP, {16'd0, dt});
        write_reg(upi_pkg::REG_START_X, sx);
        write_reg(upi_pkg::REG_START_Y, sy);
        write_reg(upi_pkg::REG_START_HEADING, {16'd0, sh});
        settings++;
    endtask

    task automatic pick_setting();
        logic [15:0] dt;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [15:0] sh;
        case ($urandom_range(0, 5))
            0:       dt = 16'd1;
            1:       dt = 16'hFFFF;
            2:       dt = 16'd655;
            default: dt = 16'($urandom_range(1, 65535));
        endcase
        sx = $urandom;
        sy = $urandom;
        sh = 16'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            sx = 32'h7FFF_FFFF;
            sy = 32'h8000_0000;
        end
        write_pose_regs(dt, sx, sy, sh);
    endtask

    task automatic test_reset_defaults();
        send_word(1'b0, 16'h0100, 16'h0000);
        send_word(1'b0, 16'h7FFF, 16'h0400);
        wait_drain();
    endtask

    task automatic test_field_extremes();
        logic [15:0] quads [0:4];
        quads = '{16'h4000, 16'h8000, 16'hC000, 16'h3FFF, 16'hC001};
        // x starts at the top of its range and wraps on the first step
        write_pose_regs(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_word(1'b1, 16'h7FFF, 16'h0000);
        send_word(1'b0, 16'h8000, 16'h8000);
        send_word(1'b0, 16'h7FFF, 16'h7FFF);
        send_word(1'b0, 16'h8000, 16'h7FFF);
        send_word(1'b0, 16'h0001, 16'h8000);
        wait_drain();
        // zero time step: pose must hold
        write_reg(upi_pkg::REG_TIME_STEP, 32'd0);
        send_word(1'b1, 16'h7FFF, 16'h7FFF);
        send_word(1'b0, 16'h8000, 16'h8000);
        wait_drain();
        write_reg(upi_pkg::REG_TIME_STEP, 32'd1);
        send_word(1'b0, 16'h7FFF, 16'h8000);
        send_word(1'b0, 16'h8000, 16'h7FFF);
        wait_drain();
        // headings on and next to the quarter-turn boundaries of the CORDIC fold, and the half turn
        write_reg(upi_pkg::REG_TIME_STEP, 32'h0000_FFFF);
        foreach (quads[k]) begin
            write_reg(upi_pkg::REG_START_HEADING, {16'd0, quads[k]});
            send_word(1'b1, 16'h7FFF, 16'h0000);
            wait_drain();
        end
        settings += 3;
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            pick_setting();
            sender_idle = ($urandom_range(0, 3) != 0);
            sink_stall  = ($urandom_range(0, 3) != 0);
            send_word(1'b1, 16'($urandom), 16'($urandom));
            for (int n = 1; n < per_phase; n++)
                send_random_word();
            wait_drain();
        end
    endtask

    task automatic test_pressure();
        sender_idle = 1'b1;
        sink_stall  = 1'b1;
        for (int r = 0; r < 4; r++) begin
            repeat (10) send_random_word();
            wait_drain();
        end
    endtask

    task automatic test_unpaced(input int count);
        pick_setting();
        sender_idle = 1'b0;
        sink_stall  = 1'b0;
        send_word(1'b1, 16'($urandom), 16'($urandom));
        repeat (count - 1) send_random_word();
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s of result %0d: expected %h, got %h",
                     field, results_seen, want, got);
    endtask

    initial begin : pose_checker
        pose_t want;
        pose_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (pose_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pose word with nothing pending: %h", m_tdata);
                end else begin
                    want = pose_queue.pop_front();
                    if (got.x !== want.x)
                        note_mismatch("pos_x", want.x, got.x);
                    if (got.y !== want.y)
                        note_mismatch("pos_y", want.y, got.y);
                    if (got.h !== want.h)
                        note_mismatch("heading", {16'd0, want.h}, {16'd0, got.h});
                end
            end
        end
    end

    initial begin : sink_driver
        int gap;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_stall && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 13);
                m_tready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    initial begin : watchdog
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : run
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = upi_pkg::REG_TIME_STEP;
        cfg_wdata       = '0;
        sender_idle     = 1'b1;
        sink_stall      = 1'b1;
        time_step_q     = 16'd655;
        start_x_q       = '0;
        start_y_q       = '0;
        start_heading_q = '0;
        pose_x_q        = '0;
        pose_y_q        = '0;
        pose_heading_q  = '0;
        words_sent      = 0;
        results_seen    = 0;
        mismatches      = 0;
        restarts        = 0;
        settings        = 1;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_random_phases(7, 220);
        test_pressure();
        test_unpaced(130);
        wait_drain();

        $display("covered %0d words (%0d with restart) under %0d register settings",
                 words_sent, restarts, settings);
        $display("checked %0d pose words, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && pose_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
